### design/utf8_decoder_with_advance_width_core_macros.svh
// assertion macros for the utf-8 decoder block
`ifndef UTF8_DECODER_WITH_ADVANCE_WIDTH_CORE_MACROS_SVH
`define UTF8_DECODER_WITH_ADVANCE_WIDTH_CORE_MACROS_SVH

// checked at every clock edge outside reset
`define UAW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every clock edge, reset included
`define UAW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/utf8aw_pkg.sv
`default_nettype none
package utf8aw_pkg;

  localparam int CP_W  = 21;
  localparam int ADV_W = 9;
  localparam int TOT_W = 16;

  localparam logic [ADV_W-1:0] ADV_MAX = 9'd511;
  localparam logic [TOT_W-1:0] TOT_MAX = 16'hFFFF;

  // register indexes
  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_NARROW = 2'd1;
  localparam logic [1:0] REG_WIDE   = 2'd2;

  localparam logic [3:0] SCALE_RST  = 4'd1;
  localparam logic [5:0] NARROW_RST = 6'd6;
  localparam logic [5:0] WIDE_RST   = 6'd16;

  // lead byte classes
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_TAG   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_TAG   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_TAG   = 8'hF0;

  localparam logic [CP_W-1:0] QMARK = 21'h3F;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            substituted;
    logic            is_last;
  } glyph_t;

  typedef struct packed {
    logic   push;
    glyph_t glyph;
  } push_t;

  typedef struct packed {
    logic [3:0] scale;
    logic [5:0] narrow_width;
    logic [5:0] wide_width;
  } cfg_t;

endpackage
`default_nettype wire

### design/utf8aw_ifs.sv
`default_nettype none
interface utf8aw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       string_end;
  modport source (output valid, data_byte, string_end, input ready);
  modport sink (input valid, data_byte, string_end, output ready);
endinterface

interface utf8aw_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [8:0]  advance;
  logic [15:0] total_width;
  logic        substituted;
  logic        is_last;
  modport source (output valid, code_point, advance, total_width, substituted, is_last,
                  input ready);
  modport sink (input valid, code_point, advance, total_width, substituted, is_last,
                output ready);
endinterface

interface utf8aw_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [5:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface
`default_nettype wire

### design/utf8_decoder_with_advance_width_core.sv
// channel   dir  payload                                             handshake
// in_ch     in   data_byte[7:0], string_end                          valid/ready
// out_ch    out  code_point[20:0], advance[8:0], total_width[15:0],  valid/ready
//                substituted, is_last
// cfg       in   reg_index[1:0], wr_data[5:0]                        valid/ready
//
// one byte per cycle while the queue has space; the byte that completes a result is decoded
// into the queue, then the width adder moves the result into the output register
// rst is synchronous: clears decode state, queue, running width and output valid,
// and loads scale 1, narrow width 6, wide width 16
// in_ch stalls only when the queue is full; cfg is always ready
`default_nettype none
module utf8_decoder_with_advance_width_core
  import utf8aw_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  utf8aw_in_if.sink    in_ch,
  utf8aw_out_if.source out_ch,
  utf8aw_cfg_if.sink   cfg
);

  // configuration registers
  cfg_t   cfg_regs;

  // front to queue
  push_t  q_push;
  logic   q_space;

  // queue to back
  logic   q_valid;
  glyph_t q_head;
  logic   q_pop;

  // config writes are registered directly, so the port never stalls
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.scale        <= SCALE_RST;
      cfg_regs.narrow_width <= NARROW_RST;
      cfg_regs.wide_width   <= WIDE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_SCALE:  cfg_regs.scale        <= cfg.wr_data[3:0];
        REG_NARROW: cfg_regs.narrow_width <= cfg.wr_data;
        REG_WIDE:   cfg_regs.wide_width   <= cfg.wr_data;
        default:    ; // unused index, write dropped
      endcase
    end
  end

  // front: byte classification and sequence assembly
  utf8aw_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_space (q_space),
    .q_push  (q_push)
  );

  // short queue of completed code points decouples decode from output stalls
  utf8aw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_space (q_space),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // back: advance width, running total and output register
  utf8aw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

### design/utf8aw_front.sv
`default_nettype none
module utf8aw_front
  import utf8aw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  utf8aw_in_if.sink   in_ch,
  input  wire logic   q_space,
  output push_t       q_push
);

  logic [CP_W-1:0] partial_code, partial_code_next;
  logic [1:0]      bytes_remaining, bytes_remaining_next;
  logic [CP_W-1:0] merged, lead_code;
  logic [1:0]      lead_count;
  logic            accept;
  logic [7:0]      b;

  assign in_ch.ready = q_space;
  assign accept      = in_ch.valid && q_space;
  assign b           = in_ch.data_byte;

  always_comb begin
    unique case (bytes_remaining)
      2'd1:    merged = partial_code | {15'b0, b[5:0]};
      2'd2:    merged = partial_code | {9'b0, b[5:0], 6'b0};
      2'd3:    merged = partial_code | {3'b0, b[5:0], 12'b0};
      default: merged = partial_code;
    endcase
  end

  always_comb begin
    partial_code_next    = partial_code;
    bytes_remaining_next = bytes_remaining;
    q_push               = '0;
    lead_code            = '0;
    lead_count           = 2'd0;
    if (accept) begin
      q_push.glyph.is_last = in_ch.string_end;
      if (bytes_remaining != 2'd0) begin
        if (bytes_remaining == 2'd1 || in_ch.string_end) begin
          q_push.push             = 1'b1;
          q_push.glyph.code_point = merged;
          partial_code_next       = '0;
          bytes_remaining_next    = 2'd0;
        end else begin
          partial_code_next    = merged;
          bytes_remaining_next = bytes_remaining - 2'd1;
        end
      end else begin
        priority if (b < ASCII_LIMIT) begin
          q_push.push             = 1'b1;
          q_push.glyph.code_point = {13'b0, b};
        end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
          lead_code  = {10'b0, b[4:0], 6'b0};
          lead_count = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
          lead_code  = {5'b0, b[3:0], 12'b0};
          lead_count = 2'd2;
        end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
          lead_code  = {b[2:0], 18'b0};
          lead_count = 2'd3;
        end else begin
          q_push.push              = 1'b1;
          q_push.glyph.code_point  = QMARK;
          q_push.glyph.substituted = 1'b1;
        end
        if (lead_count != 2'd0) begin
          if (in_ch.string_end) begin
            // sequence cut short: emit with missing bits zero
            q_push.push             = 1'b1;
            q_push.glyph.code_point = lead_code;
          end else begin
            partial_code_next    = lead_code;
            bytes_remaining_next = lead_count;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_code    <= '0;
      bytes_remaining <= 2'd0;
    end else begin
      partial_code    <= partial_code_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule
`default_nettype wire

### design/utf8aw_queue.sv
`default_nettype none
module utf8aw_queue
  import utf8aw_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire push_t  q_push,
  output logic        q_space,
  output logic        q_valid,
  output glyph_t      q_head,
  input  wire logic   q_pop
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  glyph_t            entries [Depth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push, do_pop;

  assign q_space = count != CntW'(Depth);
  assign q_valid = count != '0;
  assign q_head  = entries[rd_ptr];
  assign do_push = q_push.push && q_space;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.glyph;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/utf8aw_back.sv
`default_nettype none
module utf8aw_back
  import utf8aw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   q_valid,
  input  wire glyph_t q_head,
  output logic        q_pop,
  utf8aw_out_if.source out_ch
);

  logic [TOT_W-1:0] width_sum;
  logic [5:0]       base;
  logic [9:0]       product;
  logic [ADV_W-1:0] adv;
  logic [TOT_W:0]   sum;
  logic [TOT_W-1:0] tot;
  logic             out_valid;

  assign q_pop = q_valid && (!out_valid || out_ch.ready);

  assign base    = (q_head.code_point < CP_W'(ASCII_LIMIT)) ? cfg.narrow_width
                                                             : cfg.wide_width;
  assign product = base * cfg.scale;
  assign adv     = (product > 10'(ADV_MAX)) ? ADV_MAX : product[ADV_W-1:0];
  assign sum     = {1'b0, width_sum} + (TOT_W + 1)'(adv);
  assign tot     = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];

  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      width_sum <= '0;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
        width_sum <= q_head.is_last ? '0 : tot;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_ch.code_point  <= q_head.code_point;
      out_ch.advance     <= adv;
      out_ch.total_width <= tot;
      out_ch.substituted <= q_head.substituted;
      out_ch.is_last     <= q_head.is_last;
    end
  end

endmodule
`default_nettype wire

### design/utf8aw_checker.sv
`default_nettype none
`include "utf8_decoder_with_advance_width_core_macros.svh"
module utf8aw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [20:0] code_point,
  input wire logic [8:0]  advance,
  input wire logic [15:0] total_width,
  input wire logic        substituted,
  input wire logic        is_last
);

  `UAW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `UAW_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(total_width) && $stable(code_point) && $stable(is_last), "result changed while stalled")
  `UAW_ASSERT(a_subst_qmark, out_valid && substituted |-> code_point == 21'h3F, "substituted result is not a question mark")
  `UAW_ASSERT(a_total_ge_adv, out_valid |-> total_width >= {7'b0, advance}, "running width below own advance")
  `UAW_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result valid right after reset")

endmodule

bind utf8_decoder_with_advance_width_core utf8aw_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .code_point  (out_ch.code_point),
  .advance     (out_ch.advance),
  .total_width (out_ch.total_width),
  .substituted (out_ch.substituted),
  .is_last     (out_ch.is_last)
);
`default_nettype wire
